FILE: sv/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed integer to decimal ASCII converter.
// Included by the top level; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset
`define SITA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset
`define SITA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SITA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SITA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/sita_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
`default_nettype none

package sita_pkg;

  localparam int unsigned NUM_POS = 10;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned STEP_W  = 34;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic [POS_W-1:0] POS_TOP  = POS_W'(NUM_POS - 1);
  localparam logic [POS_W-1:0] POS_LAST = '0;

  localparam logic [STEP_W-1:0] POW10 [NUM_POS] = '{
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
    34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic skip;
    logic put_sign;
    logic put_digit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_neg;
    logic digit_zero;
    logic started;
    logic at_last;
  } stat_t;

  // Digit weight d * 10^p, picked from constant products
  function automatic logic [STEP_W-1:0] step_val(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] d);
    logic [STEP_W-1:0] r;
    r = '0;
    for (int pi = 0; pi < NUM_POS; pi++) begin
      for (int di = 1; di < 10; di++) begin
        if (p == POS_W'(pi) && d == POS_W'(di)) begin
          r = STEP_W'(di * POW10[pi]);
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sita_dpath.sv
// Datapath: magnitude register, decimal position counter and output character register.
// Depends on sita_pkg.
`default_nettype none

module sita_dpath (
  input  logic               clk,
  input  logic               rst,
  input  sita_pkg::cmd_t     cmd,
  output sita_pkg::stat_t    stat,
  input  logic signed [31:0] value,
  output logic [7:0]         ascii_char,
  output logic               last_char
);
  import sita_pkg::*;

  logic [31:0]       mag;
  logic [POS_W-1:0]  pos;
  logic              started;
  logic [8:0]        ge;
  logic [POS_W-1:0]  digit;
  logic [STEP_W-1:0] take;

  // Compare the magnitude against every multiple of the current power of ten
  for (genvar d = 1; d < 10; d++) begin : g_cmp
    assign ge[d-1] = {2'b00, mag} >= step_val(pos, POS_W'(d));
  end

  assign digit = POS_W'($countones(ge));
  assign take  = step_val(pos, digit);

  assign stat.in_neg     = value[31];
  assign stat.digit_zero = (digit == '0);
  assign stat.started    = started;
  assign stat.at_last    = (pos == POS_LAST);

  // Load the magnitude, then peel one decimal position per cycle unless a digit waits for the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_TOP;
      started <= 1'b0;
    end else if (cmd.load) begin
      mag     <= value[31] ? 32'(-value) : value;
      pos     <= POS_TOP;
      started <= 1'b0;
    end else if (cmd.skip) begin
      pos <= pos - 1'b1;
    end else if (cmd.put_digit) begin
      mag     <= mag - take[31:0];
      pos     <= pos - 1'b1;
      started <= 1'b1;
    end
  end

  // Output character register
  always_ff @(posedge clk) begin
    if (cmd.put_sign) begin
      ascii_char <= CHAR_MINUS;
      last_char  <= 1'b0;
    end else if (cmd.put_digit) begin
      ascii_char <= CHAR_ZERO + {4'b0000, digit};
      last_char  <= stat.at_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sita_ctrl.sv
// Controller: sequences sign and digit emission and owns both handshakes.
// Depends on sita_pkg.
`default_nettype none

module sita_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output sita_pkg::cmd_t  cmd,
  input  sita_pkg::stat_t stat
);
  import sita_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (stat.at_last && slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands and input stall
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        // hold the input off while reset is applied
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_SIGN: begin
        cmd.put_sign = slot_free;
      end
      ST_DIGITS: begin
        // drop leading zeros without using the output slot
        if (stat.digit_zero && !stat.started && !stat.at_last) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.put_digit = slot_free;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Hold the output valid until the request is taken
  always_comb begin
    if (cmd.put_sign || cmd.put_digit) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sita_pkg, sita_ctrl, sita_dpath and signed_int_to_decimal_ascii_assert.svh.
//
// Usage:
//   Input channel: in_valid / in_stall with the 32-bit two's complement value.
//   Output channel: out_valid / out_stall with ascii_char and last_char; one
//   request per character, most significant first, a leading '-' for negative
//   values, last_char set on the final digit.
//   A value is taken in the idle state, then the ten decimal positions are
//   resolved in turn after the sign of a negative value (leading zeros are
//   dropped in place, and each one delays the first digit). A new value is
//   taken once the last digit sits in the output register. The digit
//   sequencer resolves one decimal position per cycle while the receiver
//   does not stall, by comparing the magnitude against all multiples of that
//   power of ten at once.
//   While the receiver stalls, the pending character is held and digit
//   extraction waits for it. Reset stalls the input, empties the output
//   register and returns the sequencer to idle; no value in flight is kept.
`include "signed_int_to_decimal_ascii_assert.svh"
`default_nettype none

module signed_int_to_decimal_ascii (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         ascii_char,
  output logic               last_char
);
  import sita_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sita_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  sita_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .value      (value),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  // A character that is not the last one means a value is still being converted
  `SITA_ASSERT_IMP(a_busy_mid_run, clk, rst, out_valid && !out_stall && !last_char, in_stall, "new value taken before the run ended")
  // No leading zero reaches the output
  `SITA_ASSERT_IMP(a_no_lead_zero, clk, rst, cmd.put_digit, stat.started || !stat.digit_zero || stat.at_last, "leading zero emitted")
  // Taking a value blocks the input until its run is out
  `SITA_ASSERT_NXT(a_load_busy, clk, rst, cmd.load, in_stall, "input open right after a value was taken")

endmodule

`default_nettype wire

FILE: tb/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: converts signed integers and checks each ASCII
// character and its end-of-text mark against a predicted stream, with random idling on both ports.
// Depends only on the signed_int_to_decimal_ascii RTL.
`default_nettype none

module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam int         MAX_DIGITS  = 10;
  localparam int         RESET_CYCLES = 7;
  localparam int         RANDOM_REQUESTS = 220;
  localparam int         CALM_TAIL = 40;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         STALL_LIMIT = 2000;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         ascii_char;
  logic               last_char;

  int         pending_values[$];
  text_char_t expected_text[$];
  int         error_count = 0;
  int         send_gap = 0;
  int         hold_gap = 0;
  int         quiet_cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ascii_char(ascii_char),
    .last_char (last_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Spell one value as decimal text and queue its characters
  function automatic void spell_value(input logic [31:0] word);
    logic        neg;
    logic [31:0] mag;
    int unsigned digit_buf[MAX_DIGITS];
    int          ndig;
    text_char_t  ch;
    neg  = word[31];
    mag  = neg ? (32'd0 - word) : word;
    ndig = 0;
    do begin
      digit_buf[ndig] = mag % 10;
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < MAX_DIGITS);
    if (neg) begin
      ch.code = ASCII_MINUS;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      ch.code = ASCII_ZERO + 8'(digit_buf[i]);
      ch.last = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // Draw a value: full-width noise, a chosen digit count, or a power of ten or its neighbour
  function automatic int pick_value();
    int unsigned pow10 [MAX_DIGITS];
    int unsigned mag;
    int unsigned ndig;
    logic        neg;
    pow10[0] = 1;
    for (int i = 1; i < MAX_DIGITS; i++) pow10[i] = pow10[i-1] * 10;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1, 2: begin
        ndig = $urandom_range(1, MAX_DIGITS);
        if (ndig == MAX_DIGITS)
          mag = neg ? $urandom_range(32'd1000000000, 32'h8000_0000)
                    : $urandom_range(32'd1000000000, 32'h7fff_ffff);
        else
          mag = $urandom_range(ndig == 1 ? 0 : pow10[ndig-1], pow10[ndig] - 1);
      end
      default: begin
        mag = pow10[$urandom_range(0, MAX_DIGITS - 1)];
        case ($urandom_range(0, 2))
          0: mag = mag - 1;
          1: mag = mag + 1;
          default: ;
        endcase
      end
    endcase
    return neg ? int'(32'd0 - mag) : int'(mag);
  endfunction

  // Drive requests from the pending queue, with random gaps until the tail
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) spell_value(value);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_values.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          value    <= pending_values.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Check each accepted character and apply random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character, expected none actual %0d last %0b",
                   $time, ascii_char, last_char);
          error_count++;
        end else begin
          text_char_t want;
          want = expected_text.pop_front();
          if (ascii_char !== want.code) begin
            $display("%0t: ascii_char mismatch, expected %0d actual %0d",
                     $time, want.code, ascii_char);
            error_count++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char mismatch, expected %0b actual %0b",
                     $time, want.last, last_char);
            error_count++;
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when outstanding work makes no progress
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (pending_values.size() == 0 && !in_valid && expected_text.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Directed values: zero, single digits, powers of ten and their neighbours, extremes
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(-1);
    pending_values.push_back(9);
    pending_values.push_back(-9);
    pending_values.push_back(10);
    pending_values.push_back(-10);
    pending_values.push_back(99);
    pending_values.push_back(100);
    pending_values.push_back(-100);
    pending_values.push_back(12345);
    pending_values.push_back(-6789);
    pending_values.push_back(999999999);
    pending_values.push_back(1000000000);
    pending_values.push_back(-1000000000);
    pending_values.push_back(1000000001);
    pending_values.push_back(2147483647);
    pending_values.push_back(2147483646);
    pending_values.push_back(-2147483647);
    pending_values.push_back(int'(32'h8000_0000));
    pending_values.push_back(int'(32'h5555_5555));
    pending_values.push_back(int'(32'haaaa_aaaa));
    for (int i = 0; i < RANDOM_REQUESTS; i++) pending_values.push_back(pick_value());

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken, then for the text to drain
    while (pending_values.size() != 0 || in_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_text.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, expected_text.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/sita_pkg.sv
sv/sita_dpath.sv
sv/sita_ctrl.sv
sv/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
